>>> hdl/abp_pkg.sv
// Shared constants and types for the associative bimodal branch predictor.
// Depends on nothing; imported by hdl/assoc_bimodal_branch_predictor.sv and dv/tb.sv.
package abp_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int USED_W        = $clog2(TABLE_ENTRIES + 1);
    localparam int TAG_W         = 32;
    localparam int CTR_W         = 2;
    localparam int CNT_W         = 32;
    localparam int ABITS_W       = 6;

    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 6;

    localparam int IN_DATA_W     = 40;
    localparam int OUT_DATA_W    = 72;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_ADDRESS_BITS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_PRED = 2'd1;

    localparam logic [CTR_W-1:0] CTR_MAX = 2'd3;
    localparam logic [CTR_W-1:0] CTR_MIN = 2'd0;
    localparam logic [CTR_W-1:0] CTR_WEAK_NT = 2'd1;
    localparam logic [CTR_W-1:0] CTR_WEAK_T  = 2'd2;

    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic [CTR_W-1:0] ctr;
    } t_entry;

endpackage

>>> hdl/assoc_bimodal_branch_predictor.sv
// Top level of the associative bimodal branch predictor: one tag/counter memory,
// a sequential scan engine, running statistics and the stream ports.
// Depends on hdl/abp_pkg.sv.
// A branch is taken only in the idle state; the scan then reads the N table entries in use
// (at most 64) in order, and a hit on entry k ends it at that entry; the done step then
// writes the result beat. The block takes no new branch until that result is registered;
// the scan of the tag memory, one entry per cycle through its single read port, sets the pace,
// and a result beat still waiting for m_axis_tready holds the next one in its last step.
// Reset (synchronous, active low) clears the fill count, the statistics and the
// handshakes and restores address_bits to 30 and default_prediction to 1.
module assoc_bimodal_branch_predictor (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Input stream. tdata, low bit up: branch_address[31:0], branch_taken, zero fill.
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [abp_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // Result stream. tdata, low bit up: predicted_taken, prediction_correct, table_hit,
    // table_full, correct_total[31:0], branch_total[31:0], zero fill.
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [abp_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // Configuration write channel.
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [abp_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [abp_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import abp_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    // Configuration registers.
    logic [ABITS_W-1:0] r_address_bits;
    logic               r_default_pred;

    // Control state.
    logic [1:0]         r_state, n_state;
    logic [USED_W-1:0]  r_used, n_used;
    logic [USED_W-1:0]  r_scan_idx, n_scan_idx;
    logic               r_pend, n_pend;
    logic [IDX_W-1:0]   r_pend_idx, n_pend_idx;
    logic [CNT_W-1:0]   r_correct_cnt, n_correct_cnt;
    logic [CNT_W-1:0]   r_branch_cnt, n_branch_cnt;
    logic               r_out_valid, n_out_valid;

    // Payload registers of the item in flight and of the result beat.
    logic [TAG_W-1:0]   r_tag;
    logic               r_taken;
    logic               r_res_pred, r_res_hit, r_res_full;
    logic               n_res_pred, n_res_hit, n_res_full;
    logic [OUT_DATA_W-1:0] r_out_data;

    // Tag/counter memory, one write and one registered read per cycle.
    t_entry             mem [TABLE_ENTRIES];
    t_entry             r_rd_data;
    logic [IDX_W-1:0]   rd_addr;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    t_entry             wr_data;

    logic [TAG_W-1:0]   tag_mask;
    logic               in_beat;
    logic               tag_match;
    logic               scan_end;
    logic               table_is_full;
    logic               out_free;
    logic [CTR_W-1:0]   hit_ctr;
    logic               hit_pred;
    logic               res_correct;

    // A shift of 32 or more leaves no ones, so the mask keeps every bit, which is
    // how an address width above 32 behaves.
    assign tag_mask      = ~({TAG_W{1'b1}} << r_address_bits);
    assign in_beat       = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign out_free      = !r_out_valid || m_axis_tready;

    assign rd_addr       = r_scan_idx[IDX_W-1:0];
    assign tag_match     = r_pend && (r_rd_data.tag == r_tag);
    assign scan_end      = (r_scan_idx == r_used);
    assign table_is_full = (r_used == USED_W'(TABLE_ENTRIES));
    assign hit_ctr       = r_rd_data.ctr;
    assign hit_pred      = (hit_ctr > CTR_WEAK_NT);
    assign res_correct   = (r_res_pred == r_taken);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_address_bits <= ABITS_W'(30);
            r_default_pred <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_ADDRESS_BITS: r_address_bits <= i_cfg_data;
                REG_DEFAULT_PRED: r_default_pred <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // The scan pipelines reads: each cycle it issues the next entry and compares the
    // entry read the cycle before. Writes only happen in the cycle that ends a scan,
    // and the next scan starts after that, so no access to one entry can overlap.
    always_comb begin
        n_state       = r_state;
        n_used        = r_used;
        n_scan_idx    = r_scan_idx;
        n_pend        = 1'b0;
        n_pend_idx    = r_pend_idx;
        n_correct_cnt = r_correct_cnt;
        n_branch_cnt  = r_branch_cnt;
        n_out_valid   = r_out_valid;
        n_res_pred    = r_res_pred;
        n_res_hit     = r_res_hit;
        n_res_full    = r_res_full;
        wr_en         = 1'b0;
        wr_addr       = r_pend_idx;
        wr_data       = '{tag: r_tag, ctr: hit_ctr};

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (in_beat) begin
                    n_scan_idx = '0;
                    n_state    = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (tag_match) begin
                    // Hit: predict from the counter, then move it toward the outcome.
                    n_res_pred = hit_pred;
                    n_res_hit  = 1'b1;
                    n_res_full = 1'b0;
                    wr_en      = 1'b1;
                    wr_addr    = r_pend_idx;
                    if (r_taken) begin
                        wr_data.ctr = (hit_ctr == CTR_MAX) ? CTR_MAX : hit_ctr + CTR_W'(1);
                    end else begin
                        wr_data.ctr = (hit_ctr == CTR_MIN) ? CTR_MIN : hit_ctr - CTR_W'(1);
                    end
                    n_state = ST_DONE;
                end else if (scan_end) begin
                    // Miss: append a new entry unless the table is already full.
                    n_res_pred = r_default_pred;
                    n_res_hit  = 1'b0;
                    n_res_full = table_is_full;
                    if (!table_is_full) begin
                        wr_en       = 1'b1;
                        wr_addr     = r_used[IDX_W-1:0];
                        wr_data.ctr = r_taken ? CTR_WEAK_T : CTR_WEAK_NT;
                        n_used      = r_used + USED_W'(1);
                    end
                    n_state = ST_DONE;
                end else begin
                    n_pend     = 1'b1;
                    n_pend_idx = r_scan_idx[IDX_W-1:0];
                    n_scan_idx = r_scan_idx + USED_W'(1);
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    if (res_correct && (r_correct_cnt != {CNT_W{1'b1}})) begin
                        n_correct_cnt = r_correct_cnt + CNT_W'(1);
                    end
                    if (r_branch_cnt != {CNT_W{1'b1}}) begin
                        n_branch_cnt = r_branch_cnt + CNT_W'(1);
                    end
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_used        <= '0;
            r_scan_idx    <= '0;
            r_pend        <= 1'b0;
            r_correct_cnt <= '0;
            r_branch_cnt  <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_used        <= n_used;
            r_scan_idx    <= n_scan_idx;
            r_pend        <= n_pend;
            r_correct_cnt <= n_correct_cnt;
            r_branch_cnt  <= n_branch_cnt;
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_idx <= n_pend_idx;
        r_res_pred <= n_res_pred;
        r_res_hit  <= n_res_hit;
        r_res_full <= n_res_full;
        if (in_beat) begin
            r_tag   <= s_axis_tdata[TAG_W-1:0] & tag_mask;
            r_taken <= s_axis_tdata[TAG_W];
        end
        if ((r_state == ST_DONE) && out_free) begin
            r_out_data <= {4'b0000, n_branch_cnt, n_correct_cnt,
                           r_res_full, r_res_hit, res_correct, r_res_pred};
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rd_data <= mem[rd_addr];
    end

endmodule

>>> dv/tb.sv
// Self-checking testbench for the associative bimodal branch predictor.
// Depends on hdl/abp_pkg.sv and hdl/assoc_bimodal_branch_predictor.sv.
module tb;
    import abp_pkg::*;

    // Index values that name no register; writes to them must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    localparam int HOT_COUNT    = 24;
    localparam int PHASE_ITEMS  = 155;
    localparam int CYCLE_LIMIT  = 2000000;
    localparam int SETTLE_WAIT  = TABLE_ENTRIES + 6;

    // One result beat, unpacked from m_axis_tdata.
    typedef struct packed {
        logic             branch_total_hi_pad;
        logic [CNT_W-1:0] branch_total;
        logic [CNT_W-1:0] correct_total;
        logic             full;
        logic             hit;
        logic             correct;
        logic             pred;
    } t_prediction;

    // Mirror of the predictor: its own table, fill count, statistics and registers.
    // Every accepted branch is run through it and the outcome queued; every result
    // beat is compared against the oldest queued outcome.
    class bimodal_mirror;
        logic [TAG_W-1:0]  tags[TABLE_ENTRIES];
        logic [CTR_W-1:0]  ctrs[TABLE_ENTRIES];
        int                used;
        logic [CNT_W-1:0]  correct_count;
        logic [CNT_W-1:0]  branch_count;
        logic [ABITS_W-1:0] addr_bits;
        logic              default_pred;
        t_prediction       awaited[$];
        int                errors;
        int                hits;
        int                stored_misses;
        int                full_misses;

        function new();
            used          = 0;
            correct_count = '0;
            branch_count  = '0;
            addr_bits     = 6'd30;
            default_pred  = 1'b1;
            errors        = 0;
            hits          = 0;
            stored_misses = 0;
            full_misses   = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_ADDRESS_BITS: addr_bits = data;
                REG_DEFAULT_PRED: default_pred = data[0];
                default: ;
            endcase
        endfunction

        function void note_branch(logic [TAG_W-1:0] addr, logic taken);
            int          kept;
            logic [63:0] mask;
            logic [TAG_W-1:0] tag;
            int          slot;
            t_prediction p;
            // Widths above 32 keep the whole address; zero keeps nothing.
            kept = (addr_bits > 6'd32) ? 32 : int'(addr_bits);
            mask = (64'd1 << kept) - 64'd1;
            tag  = addr & mask[TAG_W-1:0];
            slot = -1;
            for (int k = 0; k < used; k++) begin
                if (slot < 0 && tags[k] == tag) slot = k;
            end
            p = '0;
            if (slot >= 0) begin
                p.hit  = 1'b1;
                p.pred = (ctrs[slot] >= CTR_WEAK_T);
                if (taken && ctrs[slot] != CTR_MAX) ctrs[slot] = ctrs[slot] + 2'd1;
                if (!taken && ctrs[slot] != CTR_MIN) ctrs[slot] = ctrs[slot] - 2'd1;
                hits++;
            end else begin
                p.pred = default_pred;
                if (used < TABLE_ENTRIES) begin
                    tags[used] = tag;
                    ctrs[used] = taken ? CTR_WEAK_T : CTR_WEAK_NT;
                    used++;
                    stored_misses++;
                end else begin
                    p.full = 1'b1;
                    full_misses++;
                end
            end
            p.correct = (p.pred == taken);
            if (p.correct && correct_count != '1) correct_count = correct_count + 1;
            if (branch_count != '1) branch_count = branch_count + 1;
            p.correct_total = correct_count;
            p.branch_total  = branch_count;
            awaited.push_back(p);
        endfunction

        function void compare_field(string name, logic [CNT_W-1:0] exp_v,
                                    logic [CNT_W-1:0] act_v);
            if (exp_v !== act_v) begin
                $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_prediction(logic [OUT_DATA_W-1:0] beat);
            t_prediction got;
            t_prediction exp_p;
            got = t_prediction'(beat[$bits(t_prediction)-1:0]);
            if (awaited.size() == 0) begin
                $error("result beat 0x%0h arrived with no branch outstanding", beat);
                errors++;
            end else begin
                exp_p = awaited.pop_front();
                compare_field("predicted_taken", CNT_W'(exp_p.pred), CNT_W'(got.pred));
                compare_field("prediction_correct", CNT_W'(exp_p.correct),
                              CNT_W'(got.correct));
                compare_field("table_hit", CNT_W'(exp_p.hit), CNT_W'(got.hit));
                compare_field("table_full", CNT_W'(exp_p.full), CNT_W'(got.full));
                compare_field("correct_total", exp_p.correct_total, got.correct_total);
                compare_field("branch_total", exp_p.branch_total, got.branch_total);
            end
        endfunction
    endclass

    logic                   i_clk;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_DATA_W-1:0]   s_axis_tdata  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;
    logic                   i_cfg_valid   = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data    = '0;

    bimodal_mirror mirror = new();

    int  cycle_count  = 0;
    int  stall_left   = 0;
    int  settings     = 0;
    bit  steady       = 1'b0;    // when set, neither side inserts gaps

    assoc_bimodal_branch_predictor u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Gap length for either side: mostly none or short, now and then long.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(99);
        if (steady || roll < 60) return 0;
        if (roll < 90) return $urandom_range(3, 1);
        if (roll < 98) return $urandom_range(12, 4);
        return $urandom_range(80, 20);
    endfunction

    // Result side: check each beat taken at this edge, then choose the next ready.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            mirror.check_prediction(m_axis_tdata);
        if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else begin
            stall_left = pick_gap();
            if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d results outstanding.",
                     cycle_count, mirror.awaited.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Present one branch beat and hold it until the block takes it. tvalid stays
    // high into the next call when no gap follows, so back-to-back beats are seen.
    task automatic send_branch(logic [TAG_W-1:0] addr, logic taken);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_DATA_W-TAG_W-1){1'b0}}, taken, addr};
        do @(posedge i_clk); while (!s_axis_tready);
        mirror.note_branch(addr, taken);
    endtask

    // Registers change only with the block idle: no branch pending, every result
    // returned, and then a settling wait for the scan.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (mirror.awaited.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Each write is followed by an idle gap on the channel, with i_cfg_valid low.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        mirror.write_reg(idx, data);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apply_setting(logic [ABITS_W-1:0] abits, logic [CFG_DATA_W-1:0] dflt);
        wait_idle();
        write_reg(REG_ADDRESS_BITS, abits);
        write_reg(REG_DEFAULT_PRED, dflt);
        settings++;
    endtask

    initial begin
        logic [TAG_W-1:0]   hot_addrs[HOT_COUNT];
        logic [ABITS_W-1:0] width_plan[10];
        logic [TAG_W-1:0]   addr;

        // A fixed pool of hot branches gives repeat hits across phases, including
        // after the table has filled; tag widths start narrow before the wide phases, so the fill happens gradually.
        width_plan = '{6'd1, 6'd3, 6'd5, 6'd32, 6'd63, 6'd12, 6'd33, 6'd5, 6'd32, 6'd0};
        width_plan[9] = ABITS_W'($urandom_range(63));
        foreach (hot_addrs[k]) hot_addrs[k] = $urandom();

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings (30-bit tags, default taken): a miss, then an alias of the
        // same tag through the dropped top bits, and counters driven to both rails.
        send_branch(32'h0000_0000, 1'b0);
        send_branch(32'hC000_0000, 1'b0);
        send_branch(32'h0000_0000, 1'b0);
        send_branch(32'hFFFF_FFFF, 1'b1);
        send_branch(32'hFFFF_FFFF, 1'b1);
        send_branch(32'hFFFF_FFFF, 1'b1);
        send_branch(32'hFFFF_FFFF, 1'b1);
        send_branch(32'hFFFF_FFFF, 1'b0);

        // Zero tag width: every address folds onto tag zero. The spare indexes are
        // written here too and must leave both registers alone.
        apply_setting(6'd0, 6'd0);
        write_reg(REG_SPARE_A, 6'h3F);
        write_reg(REG_SPARE_B, 6'h01);
        send_branch(32'h1234_5678, 1'b1);
        send_branch(32'hFFFF_FFFF, 1'b0);
        send_branch(32'h8000_0001, 1'b1);

        // Widths past 32 behave as a full 32-bit tag.
        apply_setting(6'd63, 6'd1);
        send_branch(32'hFFFF_FFFF, 1'b1);
        send_branch(32'h8000_0000, 1'b0);
        send_branch(32'hFFFF_FFFF, 1'b0);
        apply_setting(6'd32, 6'd0);
        send_branch(32'h7FFF_FFFF, 1'b1);
        send_branch(32'h7FFF_FFFF, 1'b1);

        // Random phases: mostly hot branches, the rest noise. The table fills during
        // the wide-tag phases, after which new tags land on a full table.
        for (int ph = 0; ph < 10; ph++) begin
            apply_setting(width_plan[ph], CFG_DATA_W'($urandom_range(63)));
            steady = (ph % 3 == 2);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(99) < 80) addr = hot_addrs[$urandom_range(HOT_COUNT-1)];
                else addr = $urandom();
                send_branch(addr, 1'($urandom_range(1)));
            end
            steady = 1'b0;
        end

        wait_idle();
        repeat (SETTLE_WAIT) @(posedge i_clk);

        $display("Ran %0d branches under %0d register settings in %0d cycles.",
                 mirror.branch_count, settings + 1, cycle_count);
        $display("Table hits %0d, misses stored %0d, misses on a full table %0d.",
                 mirror.hits, mirror.stored_misses, mirror.full_misses);
        if (mirror.errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

>>> sim.f
hdl/abp_pkg.sv
hdl/assoc_bimodal_branch_predictor.sv
dv/tb.sv
